// ===== sv/mersenne_twister_generator_assert.svh =====
// Assertion macros for the checker file mtg_checker.sv.
`ifndef MERSENNE_TWISTER_GENERATOR_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mtg_pkg.sv =====
package mtg_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int ADDR_W       = $clog2(STATE_WORDS);
	// position register also holds STATE_WORDS + 1 (never seeded)
	localparam int POS_W        = $clog2(STATE_WORDS + 2);

	localparam logic [POS_W-1:0] POS_TWIST = POS_W'(STATE_WORDS);
	localparam logic [POS_W-1:0] POS_NEVER_SEEDED = POS_W'(STATE_WORDS + 1);

	localparam logic [31:0] MAG_XOR      = 32'h9908_B0DF;
	localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
	localparam logic [31:0] LOW_BITS     = 32'h7FFF_FFFF;
	localparam logic [31:0] INIT_MULT    = 32'd1812433253;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;
	localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;

	localparam logic FUNC_SEED    = 1'b0;
	localparam logic FUNC_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEED,
		ST_READ,
		ST_WRITE
	} mtg_state_t;

	// freshly twisted word on its way to the output register
	typedef struct packed {
		logic        valid;
		logic [31:0] word;
	} mtg_result_t;

	function automatic logic [31:0] mtg_temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// ===== sv/mtg_state_ram.sv =====
module mtg_state_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== sv/mtg_seq.sv =====
module mtg_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                func,
	input  logic [31:0]         seed,
	output logic                in_stall,
	input  logic                out_hold,
	output mtg_pkg::mtg_result_t result
);
	import mtg_pkg::*;

	mtg_state_t        state_q, state_d;
	logic [POS_W-1:0]  pos_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] count_q;
	logic              pend_q;
	logic [31:0]       init_q;
	logic [31:0]       cur_q;

	logic              accept;
	logic              seed_last;
	logic              write_done;
	logic [ADDR_W-1:0] addr_a, addr_b;
	logic [31:0]       rd_a, rd_b;
	logic [31:0]       pair, twisted, init_next;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [31:0]       wdata;

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign seed_last  = (count_q == ADDR_W'(STATE_WORDS - 1));
	assign write_done = (state_q == ST_WRITE) && !out_hold;

	// neighbors of the word being twisted, with wraparound
	assign addr_a = (idx_q == ADDR_W'(STATE_WORDS - 1)) ? '0 : idx_q + ADDR_W'(1);
	assign addr_b = (idx_q >= ADDR_W'(STATE_WORDS - TWIST_OFFSET))
		? idx_q - ADDR_W'(STATE_WORDS - TWIST_OFFSET)
		: idx_q + ADDR_W'(TWIST_OFFSET);

	assign pair    = (cur_q & HIGH_BIT) | (rd_a & LOW_BITS);
	assign twisted = rd_b ^ (pair >> 1) ^ (pair[0] ? MAG_XOR : 32'd0);

	assign init_next = INIT_MULT * (init_q ^ (init_q >> 30))
		+ 32'(count_q) + 32'd1;

	assign we    = (state_q == ST_SEED) || write_done;
	assign waddr = (state_q == ST_SEED) ? count_q : idx_q;
	assign wdata = (state_q == ST_SEED) ? init_q : twisted;

	assign result.valid = write_done;
	assign result.word  = twisted;

	mtg_state_ram #(
		.WIDTH(32),
		.DEPTH(STATE_WORDS)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_SEED || pos_q == POS_NEVER_SEEDED) begin
						state_d = ST_SEED;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_SEED: begin
				if (seed_last) begin
					state_d = pend_q ? ST_READ : ST_IDLE;
				end
			end
			ST_READ: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (!out_hold) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_NEVER_SEEDED;
			idx_q   <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= '0;
						if (func == FUNC_SEED) begin
							pend_q <= 1'b0;
						end else if (pos_q == POS_NEVER_SEEDED) begin
							pend_q <= 1'b1;
						end else begin
							pend_q <= 1'b0;
							idx_q  <= (pos_q >= POS_TWIST) ? '0 : pos_q[ADDR_W-1:0];
						end
					end
				end
				ST_SEED: begin
					count_q <= count_q + ADDR_W'(1);
					if (seed_last) begin
						pos_q <= POS_TWIST;
						idx_q <= '0;
					end
				end
				ST_WRITE: begin
					if (!out_hold) begin
						pos_q <= POS_W'(idx_q) + POS_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// cur_q always mirrors the stored word at the next read position
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			init_q <= (func == FUNC_SEED) ? seed : DEFAULT_SEED;
		end
		if (state_q == ST_SEED) begin
			init_q <= init_next;
			if (count_q == '0) begin
				cur_q <= init_q;
			end
		end
		if (write_done) begin
			cur_q <= rd_a;
		end
	end

endmodule

// ===== sv/mersenne_twister_generator.sv =====
// Extract: words read in ST_READ, output register loaded as ST_WRITE ends; one at a time.
// Seed: one state word per cycle through the init multiplier, no result.
// First extract after reset seeds itself with 5489 first, then twists and returns its result.
// Each extract twists one state word in place (two reads, one write) then tempers it.
// Reset clears control and marks the generator as never seeded; state RAM is not cleared.
module mersenne_twister_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] seed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] random_word
);
	import mtg_pkg::*;

	mtg_result_t twist;
	logic        out_valid_q;
	logic [31:0] random_word_q;
	logic        out_hold;

	// The sequencer holds its twisted word while the output register
	// still carries a result that the consumer has not taken.
	assign out_hold = out_valid_q && out_stall;

	mtg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.seed     (seed),
		.in_stall (in_stall),
		.out_hold (out_hold),
		.result   (twist)
	);

	// Output register: load the tempered word, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (twist.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Tempering is a few xor/shift levels; register it straight away.
	always_ff @(posedge clk) begin
		if (twist.valid) begin
			random_word_q <= mtg_temper(twist.word);
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;

endmodule

// ===== sv/mtg_checker.sv =====
`include "mersenne_twister_generator_assert.svh"

module mtg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] random_word
);

	// a stalled result holds its value
	`MTG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(random_word), "stalled result changed")

	// every request keeps the block busy in the following cycle
	`MTG_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && !in_stall,
		in_stall, "request taken without busy cycle")

	// no result can appear in the cycle after a request when none was shown
	`MTG_ASSERT_NEXT(a_no_early_result, clk, arst_n, in_valid && !in_stall && !out_valid,
		!out_valid, "result appeared too early")

	// a shown result always carries a known word
	`MTG_ASSERT_NOW(a_valid_known, clk, arst_n, out_valid,
		!$isunknown(random_word), "result word unknown")

endmodule

bind mersenne_twister_generator mtg_checker u_checker (.*);

// ===== bench/mtg_stream_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the MT19937 generator, keeps its own copy of the
// generator state and compares every delivered word against the prediction.
module mtg_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        func,
	input  logic [31:0] seed,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] random_word,
	output int          fail_count,
	output int          pending,
	output int          words_checked,
	output int          regen_count
);
	import mtg_pkg::*;

	logic [31:0]      mt_state [0:STATE_WORDS-1];
	logic [POS_W-1:0] mt_pos;
	logic [31:0]      expected_words [$];

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	function automatic void fill_state_from_seed(input logic [31:0] s);
		logic [31:0] prev;
		mt_state[0] = s;
		for (int k = 1; k < STATE_WORDS; k++) begin
			prev = mt_state[k-1];
			mt_state[k] = INIT_MULT * (prev ^ (prev >> 30)) + 32'(k);
		end
		mt_pos = POS_TWIST;
	endfunction

	function automatic void twist_state();
		logic [31:0] pair;
		logic [31:0] mixed;
		for (int k = 0; k < STATE_WORDS; k++) begin
			pair  = (mt_state[k] & HIGH_BIT) | (mt_state[(k + 1) % STATE_WORDS] & LOW_BITS);
			mixed = pair >> 1;
			if (pair[0]) begin
				mixed = mixed ^ MAG_XOR;
			end
			mt_state[k] = mt_state[(k + TWIST_OFFSET) % STATE_WORDS] ^ mixed;
		end
		mt_pos = '0;
		regen_count++;
	endfunction

	function automatic logic [31:0] temper_word(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mt_pos = POS_NEVER_SEEDED;
			expected_words.delete();
			pending = 0;
		end else begin
			// compare first: a word can never leave in the cycle its request enters
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("word %08h with no extract waiting", random_word));
				end else begin
					if (random_word !== expected_words[0]) begin
						report_mismatch($sformatf("word %0d: got %08h, want %08h",
							words_checked, random_word, expected_words[0]));
					end
					void'(expected_words.pop_front());
					words_checked++;
				end
			end
			if (in_valid && !in_stall) begin
				if (func == FUNC_SEED) begin
					fill_state_from_seed(seed);
				end else begin
					if (mt_pos >= POS_TWIST) begin
						if (mt_pos > POS_TWIST) begin
							fill_state_from_seed(DEFAULT_SEED);
						end
						twist_state();
					end
					expected_words.push_back(temper_word(mt_state[mt_pos]));
					mt_pos = mt_pos + 1'b1;
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

// ===== bench/tb_mersenne_twister_generator.sv =====
`timescale 1ns / 1ps

module tb_mersenne_twister_generator;
	import mtg_pkg::*;

	// Generous: a seed runs long with no result and every extract may sit out
	// long gaps on both sides; the slowest legal run stays far below this.
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int          RANDOM_ITEMS = 636;
	// seeds are kept out from this point on so the final run of extracts walks
	// past the end of the state array and forces a second regeneration
	localparam int          NO_SEED_FROM = 8;
	localparam int          NO_SEED_TO   = RANDOM_ITEMS;
	// a seed gives no result; wait out any seed still running at the end
	localparam int          TAIL_CYCLES  = 700;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [31:0] seed;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] random_word;

	int          fail_count;
	int          pending;
	int          words_checked;
	int          regen_count;
	int          seeds_sent;
	int          extracts_sent;
	int unsigned cycle_count;
	// when set, neither side inserts gaps
	logic        calm;

	mersenne_twister_generator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.seed       (seed),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.random_word(random_word)
	);

	mtg_stream_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.seed         (seed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.random_word  (random_word),
		.fail_count   (fail_count),
		.pending      (pending),
		.words_checked(words_checked),
		.regen_count  (regen_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Abort if the run hangs, e.g. a request is never accepted or a word
	// never shows up.
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles with %0d words outstanding", cycle_count, pending);
		$display("FAILED: results differ");
		$finish;
	end

	// Gap length in cycles: none when calm, else mostly none, often a few, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm) begin
			return 0;
		end
		if (roll < 65) begin
			return 0;
		end
		if (roll < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Receiver: alternate free runs with stalls, changing only at the falling edge.
	initial begin : sink_pacing
		int run;
		out_stall = 1'b0;
		forever begin
			run = $urandom_range(1, 24);
			repeat (run) begin
				@(negedge clk);
				out_stall <= 1'b0;
			end
			run = pick_gap();
			repeat (run) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
		end
	end

	// Present one request and hold it until the block takes it. Valid stays
	// high straight into the next request when there is no gap.
	task automatic send_request(input logic cmd, input logic [31:0] value);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			// scramble the idle payload; the block must ignore it
			func     <= 1'($urandom_range(0, 1));
			seed     <= $urandom();
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= cmd;
		seed     <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (cmd == FUNC_SEED) begin
			seeds_sent++;
		end else begin
			extracts_sent++;
		end
	endtask

	// Drop valid and hold off until every predicted word has come back.
	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin : stimulus
		logic        cmd;
		logic [31:0] value;
		in_valid      = 1'b0;
		func          = FUNC_SEED;
		seed          = '0;
		calm          = 1'b0;
		seeds_sent    = 0;
		extracts_sent = 0;
		arst_n        = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Extract straight after reset: the block must seed itself with the
		// default seed and twist before the first word. The seed field is
		// ignored here, so give it both extremes.
		send_request(FUNC_EXTRACT, 32'hFFFF_FFFF);
		send_request(FUNC_EXTRACT, 32'h0000_0000);
		send_request(FUNC_EXTRACT, $urandom());

		// Extreme seeds, reseeding in the middle of a stream.
		send_request(FUNC_SEED, 32'h0000_0000);
		send_request(FUNC_EXTRACT, 32'hFFFF_FFFF);
		send_request(FUNC_EXTRACT, 32'h0000_0000);
		send_request(FUNC_SEED, 32'hFFFF_FFFF);
		send_request(FUNC_EXTRACT, 32'h0000_0000);

		// Two seeds back to back: only the second may count.
		send_request(FUNC_SEED, 32'h8000_0000);
		send_request(FUNC_SEED, 32'h0000_0001);
		send_request(FUNC_EXTRACT, 32'h5555_5555);
		send_request(FUNC_EXTRACT, 32'hAAAA_AAAA);

		// Explicit default seed must match the self-seeded stream.
		send_request(FUNC_SEED, DEFAULT_SEED);
		send_request(FUNC_EXTRACT, $urandom());
		send_request(FUNC_SEED, 32'h7FFF_FFFF);
		send_request(FUNC_EXTRACT, $urandom());

		// Let the pipeline run dry before the random part.
		hold_until_drained();

		// Random part: a seed, occasional reseeds before item NO_SEED_FROM, then a long
		// extract stream, alternating stretches of heavy idling and none at all.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = ((i / 120) % 3) == 1;
			if (i == RANDOM_ITEMS / 2) begin
				hold_until_drained();
			end
			if (i == 0) begin
				cmd = FUNC_SEED;
			end else if ((i < NO_SEED_FROM || i > NO_SEED_TO) && $urandom_range(0, 15) == 0) begin
				cmd = FUNC_SEED;
			end else begin
				cmd = FUNC_EXTRACT;
			end
			value = $urandom();
			send_request(cmd, value);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		// catch any stray word that would follow the last request
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d requests: %0d seeds and %0d extracts.",
			seeds_sent + extracts_sent, seeds_sent, extracts_sent);
		$display("Checked %0d words over %0d state regenerations.", words_checked, regen_count);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
